// ===== rtl/bol_pkg.sv =====
// Shared types and constants for the bounded ordered list.
package bol_pkg;

  localparam int REQ_W            = 2;
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 4;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 5;
  localparam int DEFAULT_CAPACITY   = 16;
  localparam int DEFAULT_ELEM_WIDTH = 32;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_EDIT,
    CMD_EMPTY_DUMP,
    CMD_BEGIN_DUMP,
    CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic idx_last;
  } dp_status_t;

endpackage

// ===== rtl/bounded_ordered_list.sv =====
// Top level of the bounded ordered list: controller plus datapath.
//
// Usage: drive req_type, value and position with start high; the request is
// taken at a clock edge where start is high and busy is low. Results appear on
// status, element, element_valid, count and last for one cycle with strobe
// high; the receiver must take each one in that cycle, it cannot hold them off.
// Append, insert and remove: one result the cycle after acceptance, busy stays
// low, so a new request can be taken every cycle. The entry array shifts its
// words in parallel.
// Dump: after acceptance the controller enters its dump state and the result
// registers then give one stored element per cycle, last set on the final
// one; busy is high until the final element is driven. The element stream is
// set by the single read index into the entry array. A dump of an empty list
// gives one result, with element_valid low, the cycle after acceptance.
// Reset (rst, synchronous) empties the list and drops strobe; entry contents
// are not cleared and are never shown before being written.
module bounded_ordered_list
  import bol_pkg::*;
#(
  parameter int CAPACITY   = DEFAULT_CAPACITY,
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]    position,
  output logic                busy,
  output logic                strobe,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  element,
  output logic                element_valid,
  output logic [COUNT_W-1:0]  count,
  output logic                last
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  bol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .dp_status (dp_status),
    .busy      (busy),
    .cmd       (cmd)
  );

  bol_datapath #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .value         (value),
    .position      (position),
    .dp_status     (dp_status),
    .strobe        (strobe),
    .status        (status),
    .element       (element),
    .element_valid (element_valid),
    .count         (count),
    .last          (last)
  );

endmodule

// ===== rtl/bol_ctrl.sv =====
// Controller state machine: accepts requests and sequences dumps.
module bol_ctrl
  import bol_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  dp_status_t       dp_status,
  output logic             busy,
  output ctrl_cmd_t        cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (req_type == REQ_DUMP) && !dp_status.empty) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (dp_status.idx_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    cmd.op = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type != REQ_DUMP) begin
            cmd.op = CMD_EDIT;
          end else if (dp_status.empty) begin
            cmd.op = CMD_EMPTY_DUMP;
          end else begin
            cmd.op = CMD_BEGIN_DUMP;
          end
        end
      end
      S_DUMP: begin
        busy   = 1'b1;
        cmd.op = CMD_EMIT;
      end
      default: begin
        busy   = 1'b0;
        cmd.op = CMD_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/bol_datapath.sv =====
// Datapath: entry register array, fill count, dump index and result registers.
module bol_datapath
  import bol_pkg::*;
#(
  parameter int CAPACITY   = DEFAULT_CAPACITY,
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]    position,
  output dp_status_t          dp_status,
  output logic                strobe,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  element,
  output logic                element_valid,
  output logic [COUNT_W-1:0]  count,
  output logic                last
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int WIDE = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {
    W_NONE,
    W_APPEND,
    W_INSERT,
    W_REMOVE
  } wr_kind_t;

  logic [ELEM_WIDTH-1:0] entries      [CAPACITY];
  logic [ELEM_WIDTH-1:0] entries_next [CAPACITY];
  logic [CW-1:0]         fill_count;
  logic [CW-1:0]         fill_count_next;
  logic [IW-1:0]         idx;

  logic [WIDE-1:0]       val_wide;
  logic [WIDE-1:0]       rd_wide;
  logic [ELEM_WIDTH-1:0] val_elem;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic                  pos_bad;
  logic                  full;
  logic [STATUS_W-1:0]   edit_status;
  wr_kind_t              wr_kind;

  assign val_wide = WIDE'(value);
  assign val_elem = val_wide[ELEM_WIDTH-1:0];
  assign rd_wide  = WIDE'(entries[idx]);
  assign pos_ext  = CMPW'(position);
  assign cnt_ext  = CMPW'(fill_count);
  assign pos_bad  = (pos_ext >= cnt_ext);
  assign full     = (fill_count >= CAP_C);

  assign dp_status.empty    = (fill_count == '0);
  assign dp_status.idx_last = ((CW'(idx) + CW'(1)) == fill_count);

  always_comb begin
    edit_status = ST_OK;
    wr_kind     = W_NONE;
    case (req_type)
      REQ_APPEND: begin
        if (full) begin
          edit_status = ST_OUT_OF_RANGE;
        end else begin
          wr_kind = W_APPEND;
        end
      end
      REQ_INSERT: begin
        if (pos_bad) begin
          edit_status = ST_BAD_INDEX;
        end else if (full) begin
          edit_status = ST_OUT_OF_RANGE;
        end else begin
          wr_kind = W_INSERT;
        end
      end
      REQ_REMOVE: begin
        if (pos_bad) begin
          edit_status = ST_BAD_INDEX;
        end else begin
          wr_kind = W_REMOVE;
        end
      end
      default: begin
        edit_status = ST_OK;
        wr_kind     = W_NONE;
      end
    endcase
    if (cmd.op != CMD_EDIT) begin
      wr_kind = W_NONE;
    end
  end

  // the affected entries shift in parallel; append writes only the slot at the fill count
  always_comb begin
    fill_count_next = fill_count;
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
      case (wr_kind)
        W_APPEND: begin
          if (CW'(i) == fill_count) begin
            entries_next[i] = val_elem;
          end
        end
        W_INSERT: begin
          if (CMPW'(i) == pos_ext) begin
            entries_next[i] = val_elem;
          end else if ((i > 0) && (CMPW'(i) > pos_ext)) begin
            entries_next[i] = entries[(i > 0) ? i - 1 : 0];
          end
        end
        W_REMOVE: begin
          if ((i < CAPACITY - 1) && (CMPW'(i) >= pos_ext)) begin
            entries_next[i] = entries[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        default: entries_next[i] = entries[i];
      endcase
    end
    case (wr_kind)
      W_APPEND, W_INSERT: fill_count_next = fill_count + CW'(1);
      W_REMOVE:           fill_count_next = fill_count - CW'(1);
      default:            fill_count_next = fill_count;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      idx        <= '0;
      strobe     <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      strobe     <= (cmd.op != CMD_NONE) && (cmd.op != CMD_BEGIN_DUMP);
      case (cmd.op)
        CMD_BEGIN_DUMP: idx <= '0;
        CMD_EMIT:       idx <= idx + IW'(1);
        default:        idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_EMIT: begin
        status        <= ST_OK;
        element       <= rd_wide[VALUE_W-1:0];
        element_valid <= 1'b1;
        count         <= COUNT_W'(fill_count);
        last          <= dp_status.idx_last;
      end
      CMD_EDIT, CMD_EMPTY_DUMP: begin
        status        <= (cmd.op == CMD_EDIT) ? edit_status : ST_OK;
        element       <= '0;
        element_valid <= 1'b0;
        count         <= COUNT_W'(fill_count_next);
        last          <= 1'b1;
      end
      default: begin
        status        <= status;
        element       <= element;
        element_valid <= element_valid;
        count         <= count;
        last          <= last;
      end
    endcase
  end

endmodule

// ===== rtl/bol_checker.sv =====
// Port-level checker for the bounded ordered list, bound to the top level.
module bol_assertions
  import bol_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic [REQ_W-1:0]    req_type,
  input logic                busy,
  input logic                strobe,
  input logic [STATUS_W-1:0] status,
  input logic [VALUE_W-1:0]  element,
  input logic                element_valid,
  input logic                last
);

  // a dump streams without gaps
  a_dump_continuous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("dump stream has a gap");

  // non-final dump results only while busy
  a_busy_mid_dump: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("mid-dump result without busy");

  // edit transactions give one final result next cycle
  a_edit_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type != REQ_DUMP) |=>
      strobe && last && !element_valid && (element == '0))
    else $error("edit result missing or malformed");

  // stored elements only come with ok status
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && element_valid |-> (status == ST_OK))
    else $error("element with error status");

endmodule

bind bounded_ordered_list bol_assertions u_bol_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .req_type      (req_type),
  .busy          (busy),
  .strobe        (strobe),
  .status        (status),
  .element       (element),
  .element_valid (element_valid),
  .last          (last)
);

// ===== bench/bol_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bounded ordered list: tracks the list contents and compares each result.
module bol_checker
  import bol_pkg::*;
#(
  parameter int CAPACITY   = DEFAULT_CAPACITY,
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]    position,
  input  logic                strobe,
  input  logic [STATUS_W-1:0] status,
  input  logic [VALUE_W-1:0]  element,
  input  logic                element_valid,
  input  logic [COUNT_W-1:0]  count,
  input  logic                last,
  output int                  error_count,
  output int                  pending
);

  localparam logic [VALUE_W-1:0] ELEM_MASK =
    (ELEM_WIDTH >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((64'd1 << ELEM_WIDTH) - 64'd1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  element;
    logic                element_valid;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } list_result_t;

  logic [VALUE_W-1:0] list_words [CAPACITY];
  int                 list_len = 0;
  int                 mismatches = 0;
  list_result_t       expected_results [$];
  list_result_t       head;

  assign error_count = mismatches;

  task automatic predict_request(input logic [REQ_W-1:0] kind,
                                 input logic [VALUE_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
    logic [STATUS_W-1:0] st;
    int                  idx;
    st = ST_OK;
    idx = int'(pos);
    case (kind)
      REQ_APPEND: begin
        if (list_len < CAPACITY) begin
          list_words[list_len] = val & ELEM_MASK;
          list_len++;
        end else begin
          st = ST_OUT_OF_RANGE;
        end
      end
      REQ_INSERT: begin
        if (idx >= list_len) begin
          st = ST_BAD_INDEX;
        end else if (list_len >= CAPACITY) begin
          st = ST_OUT_OF_RANGE;
        end else begin
          for (int i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
          list_words[idx] = val & ELEM_MASK;
          list_len++;
        end
      end
      REQ_REMOVE: begin
        if (idx >= list_len) begin
          st = ST_BAD_INDEX;
        end else begin
          for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: begin
        if (list_len == 0) begin
          expected_results.push_back('{ST_OK, '0, 1'b0, '0, 1'b1});
        end else begin
          for (int i = 0; i < list_len; i++)
            expected_results.push_back('{ST_OK, list_words[i], 1'b1,
                                         COUNT_W'(list_len), (i + 1 == list_len)});
        end
        return;
      end
    endcase
    expected_results.push_back('{st, '0, 1'b0, COUNT_W'(list_len), 1'b1});
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatches++;
        end else begin
          head = expected_results.pop_front();
          check_field("status", VALUE_W'(head.status), VALUE_W'(status));
          check_field("element", head.element, element);
          check_field("element_valid", VALUE_W'(head.element_valid),
                      VALUE_W'(element_valid));
          check_field("count", VALUE_W'(head.count), VALUE_W'(count));
          check_field("last", VALUE_W'(head.last), VALUE_W'(last));
        end
      end
      if (start && !busy) predict_request(req_type, value, position);
    end
    pending <= expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the bounded ordered list: stimulus, watchdog and verdict.
module tb
  import bol_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 36;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [REQ_W-1:0]    req_type = REQ_APPEND;
  logic [VALUE_W-1:0]  value = '0;
  logic [POS_W-1:0]    position = '0;
  logic                busy;
  logic                strobe;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  element;
  logic                element_valid;
  logic [COUNT_W-1:0]  count;
  logic                last;
  int                  error_count;
  int                  pending;
  int                  idle_pct = 0;
  int                  quiet_cycles = 0;

  bounded_ordered_list uut (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type), .value(value),
    .position(position), .busy(busy), .strobe(strobe), .status(status),
    .element(element), .element_valid(element_valid), .count(count), .last(last)
  );

  bol_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .value(value), .position(position), .strobe(strobe), .status(status),
    .element(element), .element_valid(element_valid), .count(count), .last(last),
    .error_count(error_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no progress for too long: hung or a result never came
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      req_type <= REQ_W'($urandom);
      value    <= $urandom;
      position <= POS_W'($urandom);
      @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    value    <= val;
    position <= pos;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_random(input int append_w, input int remove_w, input int items);
    int                 roll;
    logic [REQ_W-1:0]   kind;
    logic [POS_W-1:0]   pos;
    repeat (items) begin
      roll = $urandom_range(99);
      if (roll < append_w) kind = REQ_APPEND;
      else if (roll < append_w + 25) kind = REQ_INSERT;
      else if (roll < append_w + 25 + remove_w) kind = REQ_REMOVE;
      else kind = REQ_DUMP;
      pos = ($urandom_range(2) == 0) ? POS_W'($urandom_range(15)) : POS_W'($urandom_range(3));
      send_request(kind, $urandom, pos);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, edges of the value, bad positions, full list
    send_request(REQ_DUMP, $urandom, 4'd0);
    send_request(REQ_INSERT, $urandom, 4'd0);
    send_request(REQ_REMOVE, $urandom, 4'd0);
    send_request(REQ_APPEND, 32'h0000_0000, 4'd15);
    send_request(REQ_APPEND, 32'hFFFF_FFFF, 4'd0);
    send_request(REQ_INSERT, $urandom, 4'd2);
    send_request(REQ_INSERT, 32'hA5A5_5A5A, 4'd0);
    send_request(REQ_REMOVE, $urandom, 4'd15);
    send_request(REQ_DUMP, $urandom, 4'd0);
    repeat (13) send_request(REQ_APPEND, $urandom, POS_W'($urandom_range(15)));
    send_request(REQ_APPEND, $urandom, 4'd0);
    send_request(REQ_INSERT, $urandom, 4'd15);
    send_request(REQ_DUMP, $urandom, 4'd0);
    send_request(REQ_REMOVE, $urandom, 4'd15);
    send_request(REQ_REMOVE, $urandom, 4'd0);
    wait_drained();

    idle_pct = 0;
    run_random(45, 15, PHASE_ITEMS);
    idle_pct = 55;
    run_random(30, 30, PHASE_ITEMS);
    wait_drained();
    idle_pct = 0;
    run_random(50, 10, PHASE_ITEMS);
    idle_pct = 6;
    run_random(15, 45, PHASE_ITEMS);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bol_pkg.sv
rtl/bol_ctrl.sv
rtl/bol_datapath.sv
rtl/bounded_ordered_list.sv
rtl/bol_checker.sv
bench/bol_checker.sv
bench/tb.sv
